// ----- hw/rtl/iica_pkg.sv -----
// ----------------------------------------------------------------------------
// iica_pkg
// Shared types and codes of the integral image cell average block.
// ----------------------------------------------------------------------------
package iica_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned SAMPLE_W    = 8;
    localparam int unsigned CELL_IDX_W  = 10;
    localparam int unsigned CHAN_W      = 2;
    localparam int unsigned AVG_W       = 8;
    localparam int unsigned II_W        = 28;
    localparam int unsigned RS_W        = 18;
    localparam int unsigned DIV_STEPS   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_CNT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_SIZE    = 2'd3;

    typedef struct packed {
        logic emit;
        logic row0;
        logic col0;
        logic col_edge;
        logic row_edge;
    } iica_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } iica_state_t;

endpackage

// ----- hw/rtl/iica_ifs.sv -----
// ----------------------------------------------------------------------------
// iica_ifs
// Channel interfaces: sample requests, cell results and register writes.
// ----------------------------------------------------------------------------
interface iica_sample_if;
    logic                           valid;
    logic                           ready;
    logic [iica_pkg::SAMPLE_W-1:0]  sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface iica_cell_if;
    logic                            valid;
    logic                            ready;
    logic [iica_pkg::CELL_IDX_W-1:0] cell_row;
    logic [iica_pkg::CELL_IDX_W-1:0] cell_col;
    logic [iica_pkg::CHAN_W-1:0]     channel;
    logic [iica_pkg::AVG_W-1:0]      average;
    modport source (output valid, output cell_row, output cell_col, output channel,
                    output average, input ready);
    modport sink (input valid, input cell_row, input cell_col, input channel,
                  input average, output ready);
endinterface

interface iica_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [iica_pkg::CFG_INDEX_W-1:0]  index;
    logic [iica_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/iica_front.sv -----
// ----------------------------------------------------------------------------
// iica_front
// Raster position tracking; tags each sample with address and cell flags.
// ----------------------------------------------------------------------------
module iica_front #(
    parameter int unsigned MAX_CHANNELS = 4,
    parameter int unsigned XW           = 11,
    parameter int unsigned YW           = 11,
    parameter int unsigned CHW          = 3,
    parameter int unsigned CSW          = 7,
    parameter int unsigned AW           = 12,
    parameter int unsigned ITEM_W       = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic [XW-1:0]     width_eff,
    input  logic [YW-1:0]     height_eff,
    input  logic [CHW-1:0]    chans_eff,
    input  logic [CSW-1:0]    cell_eff,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [iica_pkg::SAMPLE_W-1:0] in_sample,
    output logic              push,
    input  logic              q_full,
    output logic [ITEM_W-1:0] push_item
);
    import iica_pkg::*;

    logic [XW-1:0]  col_reg, col_next, e_col;
    logic [YW-1:0]  row_reg, row_next, e_row;
    logic [CHW-1:0] ch_reg, ch_next, e_ch;
    logic [CSW-1:0] cic_reg, cic_next, e_cic;
    logic [CSW-1:0] ric_reg, ric_next, e_ric;
    logic [XW-1:0]  ccells_reg, ccells_next, e_ccells;
    logic [YW-1:0]  rcells_reg, rcells_next, e_rcells;
    logic           out_of_frame;
    logic [AW-1:0]  idx;
    iica_flags_t    flags;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        out_of_frame = (ch_reg >= chans_eff) || (col_reg >= width_eff) ||
                       (row_reg >= height_eff);
        e_col    = out_of_frame ? '0 : col_reg;
        e_row    = out_of_frame ? '0 : row_reg;
        e_ch     = out_of_frame ? '0 : ch_reg;
        e_cic    = out_of_frame ? '0 : cic_reg;
        e_ric    = out_of_frame ? '0 : ric_reg;
        e_ccells = out_of_frame ? '0 : ccells_reg;
        e_rcells = out_of_frame ? '0 : rcells_reg;

        idx = AW'(32'(e_col) * MAX_CHANNELS + 32'(e_ch));
        flags.row0     = (e_row == '0);
        flags.col0     = (e_col == '0);
        flags.col_edge = (e_cic == '0);
        flags.row_edge = (e_ric == '0);
        flags.emit     = !flags.row0 && !flags.col0 && flags.col_edge && flags.row_edge;
        push_item = {in_sample, e_ch, idx, CELL_IDX_W'(e_rcells - 1'b1),
                     CELL_IDX_W'(e_ccells - 1'b1), flags};

        col_next    = e_col;
        row_next    = e_row;
        ch_next     = e_ch + 1'b1;
        cic_next    = e_cic;
        ric_next    = e_ric;
        ccells_next = e_ccells;
        rcells_next = e_rcells;
        if (ch_next >= chans_eff)
        begin
            ch_next  = '0;
            col_next = e_col + 1'b1;
            cic_next = e_cic + 1'b1;
            if (cic_next >= cell_eff)
            begin
                cic_next    = '0;
                ccells_next = e_ccells + 1'b1;
            end
            if (col_next >= width_eff)
            begin
                col_next    = '0;
                cic_next    = '0;
                ccells_next = '0;
                row_next    = e_row + 1'b1;
                ric_next    = e_ric + 1'b1;
                if (ric_next >= cell_eff)
                begin
                    ric_next    = '0;
                    rcells_next = e_rcells + 1'b1;
                end
                if (row_next >= height_eff)
                begin
                    row_next    = '0;
                    ric_next    = '0;
                    rcells_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            cic_reg    <= '0;
            ric_reg    <= '0;
            ccells_reg <= '0;
            rcells_reg <= '0;
        end
        else if (restart)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            cic_reg    <= '0;
            ric_reg    <= '0;
            ccells_reg <= '0;
            rcells_reg <= '0;
        end
        else if (push)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            ch_reg     <= ch_next;
            cic_reg    <= cic_next;
            ric_reg    <= ric_next;
            ccells_reg <= ccells_next;
            rcells_reg <= rcells_next;
        end
    end

endmodule

// ----- hw/rtl/iica_queue.sv -----
// ----------------------------------------------------------------------------
// iica_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module iica_queue #(
    parameter int unsigned ITEM_W = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [ITEM_W-1:0] push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [ITEM_W-1:0] pop_item
);
    import iica_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    logic [ITEM_W-1:0] slots_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- hw/rtl/iica_back.sv -----
// ----------------------------------------------------------------------------
// iica_back
// Integral image update, four-corner box sum, serial divide, result register.
// ----------------------------------------------------------------------------
module iica_back #(
    parameter int unsigned MAX_CHANNELS = 4,
    parameter int unsigned CHW          = 3,
    parameter int unsigned AW           = 12,
    parameter int unsigned SQW          = 14,
    parameter int unsigned ITEM_W       = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SQW-1:0]    divisor,
    input  logic              q_not_empty,
    input  logic [ITEM_W-1:0] q_item,
    output logic              pop,
    iica_cell_if.source       cells
);
    import iica_pkg::*;

    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned SW    = $clog2(DIV_STEPS);
    localparam int unsigned CIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [II_W-1:0] prev_mem [DEPTH];
    logic [II_W-1:0] bnd_mem [DEPTH];
    logic [II_W-1:0] prev_rd_reg, bnd_rd_reg;
    logic [II_W-1:0] left_reg [MAX_CHANNELS];
    logic [II_W-1:0] top_reg [MAX_CHANNELS];
    logic [RS_W-1:0] rs_reg [MAX_CHANNELS];

    iica_state_t     state_reg, state_next;
    logic [SAMPLE_W-1:0]   it_sample;
    logic [CHW-1:0]        it_ch;
    logic [CIW-1:0]        it_ci;
    logic [AW-1:0]         it_idx;
    logic [CELL_IDX_W-1:0] it_crow, it_ccol;
    iica_flags_t           it_flags;
    logic [ITEM_W-1:0]     item_reg;

    logic [RS_W-1:0] rs_new;
    logic [II_W-1:0] above, ii, old, box;
    logic [II_W-1:0] rem_reg, shifted;
    logic [AVG_W-1:0] quo_reg;
    logic [SW-1:0]   step_reg;
    logic            out_valid_reg;
    logic            out_load;
    logic            prev_we, bnd_we;

    assign {it_sample, it_ch, it_idx, it_crow, it_ccol, it_flags} = item_reg;
    assign it_ci = CIW'(it_ch);

    assign pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || cells.ready);
    assign prev_we  = (state_reg == ST_CALC);
    assign bnd_we   = (state_reg == ST_CALC) && it_flags.row_edge;

    always_comb
    begin
        rs_new  = it_flags.col0 ? RS_W'(it_sample) : rs_reg[it_ci] + RS_W'(it_sample);
        above   = it_flags.row0 ? '0 : prev_rd_reg;
        ii      = above + II_W'(rs_new);
        old     = it_flags.row0 ? '0 : bnd_rd_reg;
        box     = ii + top_reg[it_ci] - old - left_reg[it_ci];
        shifted = II_W'(divisor) << step_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_not_empty) state_next = ST_CALC;
            ST_CALC: state_next = it_flags.emit ? ST_DIV : ST_IDLE;
            ST_DIV:  if (step_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[it_idx] <= ii;
        end
        if (pop)
        begin
            prev_rd_reg <= prev_mem[q_item[ITEM_W-SAMPLE_W-CHW-1 -: AW]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_we)
        begin
            bnd_mem[it_idx] <= ii;
        end
        if (pop)
        begin
            bnd_rd_reg <= bnd_mem[q_item[ITEM_W-SAMPLE_W-CHW-1 -: AW]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_CALC)
        begin
            rs_reg[it_ci] <= rs_new;
            if (it_flags.col_edge)
            begin
                top_reg[it_ci]  <= old;
                left_reg[it_ci] <= ii;
            end
            rem_reg  <= box;
            quo_reg  <= '0;
            step_reg <= SW'(DIV_STEPS - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            if (rem_reg >= shifted)
            begin
                rem_reg <= rem_reg - shifted;
                quo_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - 1'b1;
        end
        if (out_load)
        begin
            cells.cell_row <= it_crow;
            cells.cell_col <= it_ccol;
            cells.channel  <= CHAN_W'(it_ch);
            cells.average  <= quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cells.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cells.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("back state not one-hot");
    a_calc_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_CALC)
        else $error("popped request not processed");
    a_div_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) && !it_flags.emit |=> state_reg == ST_IDLE)
        else $error("divide started for a non-boundary request");
`endif

endmodule

// ----- hw/rtl/integral_image_cell_average.sv -----
// ----------------------------------------------------------------------------
// integral_image_cell_average
// Box average of each square cell of a raster image via its integral image.
// ----------------------------------------------------------------------------
// samples: one 8-bit channel value per request, raster order, channels
//   interleaved. cells: one result per channel at each pixel whose row and
//   column are both nonzero multiples of the cell side; cfg: register writes
//   (0 frame_width, 1 frame_height, 2 channel_count, 3 cell side), always
//   ready; every write restarts the frame. Write only while the block idles.
// Processing: a sample without a result takes a memory read, then integral
//   update and write back; a sample that closes a cell also passes the
//   8-step serial divider and the result register load, after which the
//   result is offered. The next sample is taken from the queue only once
//   the back end is idle again.
// A 4-entry queue decouples intake from the integral pipeline, so intake
//   keeps running until it fills.
// Reset: registers return to 1, 1, 3, 1 and positions to the frame start;
//   the row memories need no clearing since a frame writes them first.
// Stall: a held result stops the back end once the next result is ready;
//   samples keep flowing until then, and intake until the queue fills.
// ----------------------------------------------------------------------------
module integral_image_cell_average #(
    parameter int unsigned MAX_WIDTH    = 1024,
    parameter int unsigned MAX_HEIGHT   = 1024,
    parameter int unsigned MAX_CHANNELS = 4,
    parameter int unsigned MAX_CELL     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    iica_sample_if.sink samples,
    iica_cell_if.source cells,
    iica_cfg_if.sink    cfg
);
    import iica_pkg::*;

    localparam int unsigned XW     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW     = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CHW    = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned CSW    = $clog2(MAX_CELL + 1);
    localparam int unsigned SQW    = 2 * CSW;
    localparam int unsigned AW     = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int unsigned ITEM_W = SAMPLE_W + CHW + AW + 2 * CELL_IDX_W
                                     + $bits(iica_flags_t);

    logic [XW-1:0]  width_reg;
    logic [YW-1:0]  height_reg;
    logic [CHW-1:0] chans_reg;
    logic [CSW-1:0] cell_reg;
    logic [SQW-1:0] cell_sq_reg;
    logic           cfg_write;
    logic [31:0]    d_all, d_chan, d_cell;
    logic           push, q_full, pop, q_not_empty;
    logic [ITEM_W-1:0] push_item, pop_item;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;
    assign d_all     = 32'(cfg.data);
    assign d_chan    = 32'(cfg.data[2:0]);
    assign d_cell    = 32'(cfg.data[6:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= XW'(1);
            height_reg <= YW'(1);
            chans_reg  <= CHW'((MAX_CHANNELS < 3) ? MAX_CHANNELS : 3);
            cell_reg   <= CSW'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:
                    width_reg <= (d_all == 0) ? XW'(1) :
                                 (d_all > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(d_all);
                REG_FRAME_HEIGHT:
                    height_reg <= (d_all == 0) ? YW'(1) :
                                  (d_all > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(d_all);
                REG_CHANNEL_CNT:
                    chans_reg <= (d_chan == 0) ? CHW'(1) :
                                 (d_chan > MAX_CHANNELS) ? CHW'(MAX_CHANNELS) : CHW'(d_chan);
                REG_CELL_SIZE:
                    cell_reg <= (d_cell == 0) ? CSW'(1) :
                                (d_cell > MAX_CELL) ? CSW'(MAX_CELL) : CSW'(d_cell);
                default:
                    cell_reg <= cell_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cell_sq_reg <= SQW'(cell_reg) * SQW'(cell_reg);
    end

    iica_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .XW           (XW),
        .YW           (YW),
        .CHW          (CHW),
        .CSW          (CSW),
        .AW           (AW),
        .ITEM_W       (ITEM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_write),
        .width_eff  (width_reg),
        .height_eff (height_reg),
        .chans_eff  (chans_reg),
        .cell_eff   (cell_reg),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .in_sample  (samples.sample),
        .push       (push),
        .q_full     (q_full),
        .push_item  (push_item)
    );

    iica_queue #(
        .ITEM_W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    iica_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CHW          (CHW),
        .AW           (AW),
        .SQW          (SQW),
        .ITEM_W       (ITEM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (cell_sq_reg),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .pop         (pop),
        .cells       (cells)
    );

endmodule
